@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cond at one edge implies prop at the next edge.
`define ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ hw/rtl/esd_pkg.sv @@
// Types, character codes and the hex digit helper for the escape decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  localparam int unsigned LengthBits = 16;
  localparam logic [LengthBits-1:0] CountMax = '1;

  localparam logic [7:0] CharNul       = 8'h00;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharR         = 8'h72;
  localparam logic [7:0] CharX         = 8'h78;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharNine      = 8'h39;
  localparam logic [7:0] CharLowA      = 8'h61;
  localparam logic [7:0] CharLowF      = 8'h66;
  localparam logic [7:0] CharUpA       = 8'h41;
  localparam logic [7:0] CharUpF       = 8'h46;
  localparam logic [7:0] ByteNewline   = 8'h0A;
  localparam logic [7:0] ByteCr        = 8'h0D;
  localparam logic [7:0] HexAlphaBase  = 8'd10;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_BACKSLASH = 2'd1,
    MODE_HEX1      = 2'd2,
    MODE_HEX2      = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                 mode;
    logic [3:0]            nibble;
    logic [LengthBits-1:0] count;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic        done;
    logic [15:0] length;
  } result_t;

  localparam state_t StateReset = '{mode: MODE_NORMAL, nibble: 4'h0, count: '0};

  // {is_hex, value}
  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= CharZero && c <= CharNine) begin
      return {1'b1, 4'(c - CharZero)};
    end else if (c >= CharLowA && c <= CharLowF) begin
      return {1'b1, 4'(c - CharLowA + HexAlphaBase)};
    end else if (c >= CharUpA && c <= CharUpF) begin
      return {1'b1, 4'(c - CharUpA + HexAlphaBase)};
    end
    return 5'h00;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/escape_sequence_decoder_core.sv @@
// Stages: input register, then result register.
// Throughput: one character per cycle while results are taken; next state is combinational from state_q.
// Reset: rst_ni low clears both stage valids and the decode state (mode normal, count zero).
// A held result stalls the input only once the input register also holds a word.
// Top level of the escape decoder: input register, decode logic, result register.
// Depends on esd_pkg, esd_decode and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module escape_sequence_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        done_res_o,
  output logic [15:0] total_length_o
);
  import esd_pkg::*;

  logic    s1_valid_q;
  logic    s1_valid_d;
  logic [7:0] char_q;
  logic    res_valid_q;
  logic    res_valid_d;
  result_t res_q;
  result_t res_d;
  state_t  state_q;
  state_t  state_d;
  logic    adv;
  logic    in_fire;

  assign adv        = s1_valid_q && (!res_valid_q || res_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  esd_decode u_decode (
    .char_i   (char_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (adv) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= char_in_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign out_valid_o    = res_q.valid;
  assign out_byte_o     = res_q.data;
  assign done_res_o     = res_q.done;
  assign total_length_o = res_q.length;

  `ASSERT_CLK(a_done_no_byte, (res_valid_q && res_q.done) |-> !res_q.valid, "done with byte")
  `ASSERT_NEXT(a_done_resets, adv && res_d.done,
               state_q.mode == MODE_NORMAL && state_q.count == '0, "state not reset after done")
  `ASSERT_NEXT(a_count_grows, adv && !res_d.done,
               state_q.count >= $past(state_q.count), "count decreased")
  `ASSERT_NEXT(a_stage_full_stall, s1_valid_q && !adv, s1_valid_q, "input stage lost a word")

endmodule

`default_nettype wire

@@ hw/rtl/esd_decode.sv @@
// Next-state and result logic for one character of the escape decoder.
// Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_decode (
  input  logic [7:0]       char_i,
  input  esd_pkg::state_t  state_i,
  output esd_pkg::state_t  state_o,
  output esd_pkg::result_t result_o
);
  import esd_pkg::*;

  logic [4:0]            hex;
  logic                  emit;
  logic [7:0]            data;
  state_t                st;
  logic [LengthBits-1:0] count_n;

  assign hex = hex_value(char_i);

  always_comb begin
    emit = 1'b0;
    data = 8'h00;
    st   = state_i;
    unique case (state_i.mode)
      MODE_NORMAL: begin
        if (char_i == CharBackslash) begin
          st.mode = MODE_BACKSLASH;
        end else begin
          emit = 1'b1;
          data = char_i;
        end
      end
      MODE_BACKSLASH: begin
        st.mode = MODE_NORMAL;
        priority if (char_i == CharN) begin
          emit = 1'b1;
          data = ByteNewline;
        end else if (char_i == CharR) begin
          emit = 1'b1;
          data = ByteCr;
        end else if (char_i == CharBackslash) begin
          emit = 1'b1;
          data = CharBackslash;
        end else if (char_i == CharX) begin
          st.mode = MODE_HEX1;
        end else begin
          st.mode = MODE_NORMAL;
        end
      end
      MODE_HEX1: begin
        if (hex[4]) begin
          st.nibble = hex[3:0];
          st.mode   = MODE_HEX2;
        end else begin
          st.mode = MODE_NORMAL;
        end
      end
      MODE_HEX2: begin
        st.mode = MODE_NORMAL;
        if (hex[4]) begin
          emit = 1'b1;
          data = {state_i.nibble, hex[3:0]};
        end
      end
      default: st.mode = MODE_NORMAL;
    endcase
  end

  assign count_n = (emit && state_i.count != CountMax) ? state_i.count + 1'b1 : state_i.count;

  always_comb begin
    if (char_i == CharNul) begin
      state_o         = StateReset;
      result_o.valid  = 1'b0;
      result_o.data   = 8'h00;
      result_o.done   = 1'b1;
      result_o.length = 16'(state_i.count);
    end else begin
      state_o         = st;
      state_o.count   = count_n;
      result_o.valid  = emit;
      result_o.data   = data;
      result_o.done   = 1'b0;
      result_o.length = 16'(count_n);
    end
  end

endmodule

`default_nettype wire
